FILE: hdl/gpio_prb_pkg.sv
// Package: address map and register offsets of the GPIO port register block.
package gpio_prb_pkg;

  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned PINS_W   = 16;
  localparam int unsigned OFS_W    = 10;
  localparam int unsigned PAGE_W   = ADDR_W - OFS_W;
  localparam int unsigned PORT_CNT = 4;
  localparam int unsigned PORT_W   = 2;

  typedef logic [PORT_W-1:0] port_idx_t;
  typedef logic [OFS_W-1:0]  reg_ofs_t;
  typedef logic [PAGE_W-1:0] page_t;

  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  // 1 KiB pages of each port
  localparam page_t PAGE_LEG_P0 = page_t'(32'h4001_0800 >> OFS_W);
  localparam page_t PAGE_LEG_P1 = page_t'(32'h4001_0C00 >> OFS_W);
  localparam page_t PAGE_LEG_P2 = page_t'(32'h4001_1000 >> OFS_W);
  localparam page_t PAGE_NEW_P0 = page_t'(32'h4800_0000 >> OFS_W);
  localparam page_t PAGE_NEW_P1 = page_t'(32'h4800_0400 >> OFS_W);
  localparam page_t PAGE_NEW_P3 = page_t'(32'h4800_1400 >> OFS_W);

  localparam port_idx_t PORT_0 = 2'd0;
  localparam port_idx_t PORT_1 = 2'd1;
  localparam port_idx_t PORT_2 = 2'd2;
  localparam port_idx_t PORT_3 = 2'd3;

  // legacy layout
  localparam reg_ofs_t LEG_CFG_LO  = 10'h000;
  localparam reg_ofs_t LEG_CFG_HI  = 10'h004;
  localparam reg_ofs_t LEG_IN      = 10'h008;
  localparam reg_ofs_t LEG_OUT     = 10'h00C;
  localparam reg_ofs_t LEG_SET_RST = 10'h010;
  localparam reg_ofs_t LEG_BIT_RST = 10'h014;

  // new layout
  localparam reg_ofs_t NEW_MODE    = 10'h000;
  localparam reg_ofs_t NEW_OTYPE   = 10'h004;
  localparam reg_ofs_t NEW_IN      = 10'h008;
  localparam reg_ofs_t NEW_OUT     = 10'h00C;
  localparam reg_ofs_t NEW_CLR     = 10'h010;
  localparam reg_ofs_t NEW_SET     = 10'h014;
  localparam reg_ofs_t NEW_SET_RST = 10'h018;
  localparam reg_ofs_t NEW_LOCK    = 10'h01C;
  localparam reg_ofs_t NEW_AF_LO   = 10'h020;
  localparam reg_ofs_t NEW_AF_HI   = 10'h024;
  localparam reg_ofs_t NEW_BIT_RST = 10'h028;

endpackage

FILE: hdl/gpio_port_register_block.sv
// GPIO port register block: four ports, legacy and new register layouts.
// One bus access is taken per cycle while in_stall is low. An accepted
// transaction is held in an input register, where the address is decoded,
// the register file is read and updated, and the result is loaded into the
// output register as the transaction advances from the input register.
// Writes take effect as the transaction leaves the input register, so each
// access sees every earlier one. A stall on the output holds both stages;
// the input accepts whenever its register is empty or advancing.
// Only the low PIN_COUNT pins of each port are stored and read back.
module gpio_port_register_block #(
  parameter int unsigned PIN_COUNT = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_mode,
  input  logic [gpio_prb_pkg::ADDR_W-1:0] in_address,
  input  logic [gpio_prb_pkg::DATA_W-1:0] in_write_data,
  input  logic [gpio_prb_pkg::PINS_W-1:0] in_pin_levels,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [gpio_prb_pkg::DATA_W-1:0] out_read_data,
  output logic                           out_address_hit
);
  import gpio_prb_pkg::*;

  typedef logic [PIN_COUNT-1:0] pins_t;

  // input stage
  logic                s1_valid_r;
  logic                s1_mode_r;
  logic [ADDR_W-1:0]   s1_addr_r;
  logic [DATA_W-1:0]   s1_wdata_r;
  logic [PINS_W-1:0]   s1_pins_r;

  // result stage
  logic                out_valid_r;
  logic [DATA_W-1:0]   out_read_data_r;
  logic                out_address_hit_r;

  // register file
  pins_t               latch_r   [PORT_CNT];
  logic [DATA_W-1:0]   cfg_lo_r  [PORT_CNT];
  logic [DATA_W-1:0]   cfg_hi_r  [PORT_CNT];
  logic [DATA_W-1:0]   mode_r    [PORT_CNT];
  logic [DATA_W-1:0]   otype_r   [PORT_CNT];
  logic [DATA_W-1:0]   lock_r    [PORT_CNT];
  logic [DATA_W-1:0]   af_lo_r   [PORT_CNT];
  logic [DATA_W-1:0]   af_hi_r   [PORT_CNT];

  logic                s1_adv;
  logic                hit;
  logic                legacy;
  port_idx_t           port;
  page_t               page;
  reg_ofs_t            ofs;
  logic                wr;
  pins_t               pins;
  pins_t               cur_latch;
  pins_t               wd_lo;
  pins_t               wd_hi;
  pins_t               latch_nxt;
  logic                latch_we;
  logic                cfg_lo_we, cfg_hi_we, mode_we, otype_we, lock_we, af_lo_we, af_hi_we;
  logic [DATA_W-1:0]   rd;
  logic [DATA_W-1:0]   read_data_nxt;

  assign s1_adv   = ~out_valid_r | ~out_stall;
  assign in_stall = s1_valid_r & ~s1_adv;

  assign page      = s1_addr_r[ADDR_W-1:OFS_W];
  assign ofs       = s1_addr_r[OFS_W-1:0];
  assign wr        = (s1_mode_r == MODE_WRITE);
  assign pins      = s1_pins_r[PIN_COUNT-1:0];
  assign wd_lo     = s1_wdata_r[PIN_COUNT-1:0];
  assign wd_hi     = s1_wdata_r[PINS_W +: PIN_COUNT];
  assign cur_latch = latch_r[port];

  // port and layout decode
  always_comb begin
    hit    = 1'b1;
    legacy = 1'b0;
    port   = PORT_0;
    case (page)
      PAGE_LEG_P0: begin legacy = 1'b1; port = PORT_0; end
      PAGE_LEG_P1: begin legacy = 1'b1; port = PORT_1; end
      PAGE_LEG_P2: begin legacy = 1'b1; port = PORT_2; end
      PAGE_NEW_P0: port = PORT_0;
      PAGE_NEW_P1: port = PORT_1;
      PAGE_NEW_P3: port = PORT_3;
      default:     hit = 1'b0;
    endcase
  end

  // register read and update
  always_comb begin
    rd        = '0;
    latch_nxt = cur_latch;
    latch_we  = 1'b0;
    cfg_lo_we = 1'b0;
    cfg_hi_we = 1'b0;
    mode_we   = 1'b0;
    otype_we  = 1'b0;
    lock_we   = 1'b0;
    af_lo_we  = 1'b0;
    af_hi_we  = 1'b0;
    if (legacy) begin
      case (ofs)
        LEG_CFG_LO: begin
          rd        = cfg_lo_r[port];
          cfg_lo_we = wr;
        end
        LEG_CFG_HI: begin
          rd        = cfg_hi_r[port];
          cfg_hi_we = wr;
        end
        LEG_IN:  rd = DATA_W'(pins | cur_latch);
        LEG_OUT: begin
          rd        = DATA_W'(cur_latch);
          latch_we  = wr;
          latch_nxt = wd_lo;
        end
        LEG_SET_RST: begin
          latch_we  = wr;
          latch_nxt = (cur_latch | wd_lo) & ~wd_hi;
        end
        LEG_BIT_RST: begin
          latch_we  = wr;
          latch_nxt = cur_latch & ~wd_lo;
        end
        default: rd = '0;
      endcase
    end else begin
      case (ofs)
        NEW_MODE: begin
          rd      = mode_r[port];
          mode_we = wr;
        end
        NEW_OTYPE: begin
          rd       = otype_r[port];
          otype_we = wr;
        end
        NEW_IN: rd = DATA_W'(pins | cur_latch);
        NEW_OUT: begin
          rd        = DATA_W'(cur_latch);
          latch_we  = wr;
          latch_nxt = wd_lo;
        end
        NEW_CLR, NEW_BIT_RST: begin
          rd        = (ofs == NEW_CLR) ? DATA_W'(pins | cur_latch) : '0;
          latch_we  = wr;
          latch_nxt = cur_latch & ~wd_lo;
        end
        NEW_SET: begin
          rd        = DATA_W'(cur_latch);
          latch_we  = wr;
          latch_nxt = cur_latch | wd_lo;
        end
        NEW_SET_RST: begin
          latch_we  = wr;
          latch_nxt = (cur_latch | wd_lo) & ~wd_hi;
        end
        NEW_LOCK: begin
          rd      = lock_r[port];
          lock_we = wr;
        end
        NEW_AF_LO: begin
          rd       = af_lo_r[port];
          af_lo_we = wr;
        end
        NEW_AF_HI: begin
          rd       = af_hi_r[port];
          af_hi_we = wr;
        end
        default: rd = '0;
      endcase
    end
    read_data_nxt = (hit && !wr) ? rd : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < PORT_CNT; i++) begin
        latch_r[i]  <= '0;
        cfg_lo_r[i] <= '0;
        cfg_hi_r[i] <= '0;
        mode_r[i]   <= '0;
        otype_r[i]  <= '0;
        lock_r[i]   <= '0;
        af_lo_r[i]  <= '0;
        af_hi_r[i]  <= '0;
      end
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
      // commit writes as the transaction moves to the result stage
      if (s1_valid_r && s1_adv && hit) begin
        if (latch_we)  latch_r[port]  <= latch_nxt;
        if (cfg_lo_we) cfg_lo_r[port] <= s1_wdata_r;
        if (cfg_hi_we) cfg_hi_r[port] <= s1_wdata_r;
        if (mode_we)   mode_r[port]   <= s1_wdata_r;
        if (otype_we)  otype_r[port]  <= s1_wdata_r;
        if (lock_we)   lock_r[port]   <= s1_wdata_r;
        if (af_lo_we)  af_lo_r[port]  <= s1_wdata_r;
        if (af_hi_we)  af_hi_r[port]  <= s1_wdata_r;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_mode_r  <= in_mode;
      s1_addr_r  <= in_address;
      s1_wdata_r <= in_write_data;
      s1_pins_r  <= in_pin_levels;
    end
    if (s1_valid_r && s1_adv) begin
      out_read_data_r   <= read_data_nxt;
      out_address_hit_r <= hit;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_data   = out_read_data_r;
  assign out_address_hit = out_address_hit_r;

endmodule
